>>> src/dop_pkg.sv
`timescale 1ns / 1ps

package dop_pkg;

    localparam int MAX_FRAME_BYTES = 2048;
    localparam int OFF_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int Q_DEPTH         = 4;
    localparam int Q_PTR_W         = $clog2(Q_DEPTH);
    localparam int Q_CNT_W         = $clog2(Q_DEPTH + 1);

    localparam int OFF_IP_VER   = 14;
    localparam int OFF_PROTO    = 23;
    localparam int OFF_SPORT_HI = 34;
    localparam int OFF_SPORT_LO = 35;
    localparam int OFF_DPORT_HI = 36;
    localparam int OFF_DPORT_LO = 37;
    localparam int OFF_OP       = 42;
    localparam int OFF_HTYPE    = 43;
    localparam int OFF_HLEN     = 44;
    localparam int OFF_XID0     = 46;
    localparam int OFF_XID1     = 47;
    localparam int OFF_XID2     = 48;
    localparam int OFF_XID3     = 49;
    localparam int OFF_YI0      = 58;
    localparam int OFF_YI3      = 61;
    localparam int OFF_CK0      = 278;
    localparam int OFF_CK1      = 279;
    localparam int OFF_CK2      = 280;
    localparam int OFF_CK3      = 281;
    localparam int OFF_OPT      = 282;

    localparam logic [7:0] IP_VER_IHL  = 8'h45;
    localparam logic [7:0] PROTO_UDP   = 8'd17;
    localparam logic [7:0] PORT_SERVER = 8'd67;
    localparam logic [7:0] PORT_CLIENT = 8'd68;
    localparam logic [7:0] OP_REPLY    = 8'd2;
    localparam logic [7:0] HTYPE_ETH   = 8'd1;
    localparam logic [7:0] HLEN_ETH    = 8'd6;
    localparam logic [7:0] COOKIE0     = 8'h63;
    localparam logic [7:0] COOKIE1     = 8'h82;
    localparam logic [7:0] COOKIE2     = 8'h53;
    localparam logic [7:0] COOKIE3     = 8'h63;

    localparam logic [7:0] OPT_PAD    = 8'h00;
    localparam logic [7:0] OPT_MASK   = 8'd1;
    localparam logic [7:0] OPT_ROUTER = 8'd3;
    localparam logic [7:0] OPT_DNS    = 8'd6;
    localparam logic [7:0] OPT_END    = 8'hFF;
    localparam logic [7:0] CAP_BYTES  = 8'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_IP_HDR    = 3'd1;
    localparam logic [2:0] ST_NOT_UDP   = 3'd2;
    localparam logic [2:0] ST_PORTS     = 3'd3;
    localparam logic [2:0] ST_BOOTP     = 3'd4;
    localparam logic [2:0] ST_XID       = 3'd5;
    localparam logic [2:0] ST_COOKIE    = 3'd6;
    localparam logic [2:0] ST_TRUNCATED = 3'd7;

    typedef enum logic [1:0] {
        K_IGNORE  = 2'd0,
        K_CHECK   = 2'd1,
        K_CAPTURE = 2'd2,
        K_OPTION  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        kind_t      kind;
        logic [7:0] expect_byte;
        logic [2:0] err;
        logic       hdr_end;
    } cls_word_t;

    typedef struct packed {
        logic [31:0] dns_ip;
        logic [31:0] router_ip;
        logic [31:0] subnet_mask;
        logic [31:0] offered_ip;
        logic        bound;
        logic [2:0]  status;
    } result_t;

endpackage

>>> src/dop_front.sv
`timescale 1ns / 1ps

module dop_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [7:0]           in_data,
    input  logic                 in_last,
    output dop_pkg::cls_word_t   word
);

    logic [dop_pkg::OFF_W-1:0] off_reg;
    logic [dop_pkg::OFF_W-1:0] off_next;
    logic [31:0]               tid_reg;
    logic [31:0]               tid_next;
    logic                      accept;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        tid_next = cfg_wr_en ? cfg_wr_data : tid_reg;
        off_next = off_reg;
        if (accept)
        begin
            if (in_last)
            begin
                off_next = '0;
            end
            else if (off_reg < dop_pkg::OFF_W'(dop_pkg::MAX_FRAME_BYTES))
            begin
                off_next = off_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg <= '0;
            tid_reg <= '0;
        end
        else
        begin
            off_reg <= off_next;
            tid_reg <= tid_next;
        end
    end

    // classify by frame offset
    always_comb
    begin
        word.data        = in_data;
        word.last        = in_last;
        word.kind        = dop_pkg::K_IGNORE;
        word.expect_byte = '0;
        word.err         = dop_pkg::ST_OK;
        word.hdr_end     = 1'b0;
        if (off_reg >= dop_pkg::OFF_W'(dop_pkg::MAX_FRAME_BYTES))
        begin
            word.kind = dop_pkg::K_IGNORE;
        end
        else if (off_reg >= dop_pkg::OFF_W'(dop_pkg::OFF_OPT))
        begin
            word.kind = dop_pkg::K_OPTION;
        end
        else if (off_reg >= dop_pkg::OFF_W'(dop_pkg::OFF_YI0)
                 && off_reg <= dop_pkg::OFF_W'(dop_pkg::OFF_YI3))
        begin
            word.kind = dop_pkg::K_CAPTURE;
        end
        else
        begin
            case (off_reg)
                dop_pkg::OFF_W'(dop_pkg::OFF_IP_VER):
                begin
                    word.kind = dop_pkg::K_CHECK;
                    word.expect_byte = dop_pkg::IP_VER_IHL;
                    word.err = dop_pkg::ST_IP_HDR;
                end
                dop_pkg::OFF_W'(dop_pkg::OFF_PROTO):
                begin
                    word.kind = dop_pkg::K_CHECK;
                    word.expect_byte = dop_pkg::PROTO_UDP;
                    word.err = dop_pkg::ST_NOT_UDP;
                end
                dop_pkg::OFF_W'(dop_pkg::OFF_SPORT_HI),
                dop_pkg::OFF_W'(dop_pkg::OFF_DPORT_HI):
                begin
                    word.kind = dop_pkg::K_CHECK;
                    word.expect_byte = 8'd0;
                    word.err = dop_pkg::ST_PORTS;
                end
                dop_pkg::OFF_W'(dop_pkg::OFF_SPORT_LO):
                begin
                    word.kind = dop_pkg::K_CHECK;
                    word.expect_byte = dop_pkg::PORT_SERVER;
                    word.err = dop_pkg::ST_PORTS;
                end
                dop_pkg::OFF_W'(dop_pkg::OFF_DPORT_LO):
                begin
                    word.kind = dop_pkg::K_CHECK;
                    word.expect_byte = dop_pkg::PORT_CLIENT;
                    word.err = dop_pkg::ST_PORTS;
                end
                dop_pkg::OFF_W'(dop_pkg::OFF_OP):
                begin
                    word.kind = dop_pkg::K_CHECK;
                    word.expect_byte = dop_pkg::OP_REPLY;
                    word.err = dop_pkg::ST_BOOTP;
                end
                dop_pkg::OFF_W'(dop_pkg::OFF_HTYPE):
                begin
                    word.kind = dop_pkg::K_CHECK;
                    word.expect_byte = dop_pkg::HTYPE_ETH;
                    word.err = dop_pkg::ST_BOOTP;
                end
                dop_pkg::OFF_W'(dop_pkg::OFF_HLEN):
                begin
                    word.kind = dop_pkg::K_CHECK;
                    word.expect_byte = dop_pkg::HLEN_ETH;
                    word.err = dop_pkg::ST_BOOTP;
                end
                dop_pkg::OFF_W'(dop_pkg::OFF_XID0):
                begin
                    word.kind = dop_pkg::K_CHECK;
                    word.expect_byte = tid_reg[31:24];
                    word.err = dop_pkg::ST_XID;
                end
                dop_pkg::OFF_W'(dop_pkg::OFF_XID1):
                begin
                    word.kind = dop_pkg::K_CHECK;
                    word.expect_byte = tid_reg[23:16];
                    word.err = dop_pkg::ST_XID;
                end
                dop_pkg::OFF_W'(dop_pkg::OFF_XID2):
                begin
                    word.kind = dop_pkg::K_CHECK;
                    word.expect_byte = tid_reg[15:8];
                    word.err = dop_pkg::ST_XID;
                end
                dop_pkg::OFF_W'(dop_pkg::OFF_XID3):
                begin
                    word.kind = dop_pkg::K_CHECK;
                    word.expect_byte = tid_reg[7:0];
                    word.err = dop_pkg::ST_XID;
                end
                dop_pkg::OFF_W'(dop_pkg::OFF_CK0):
                begin
                    word.kind = dop_pkg::K_CHECK;
                    word.expect_byte = dop_pkg::COOKIE0;
                    word.err = dop_pkg::ST_COOKIE;
                end
                dop_pkg::OFF_W'(dop_pkg::OFF_CK1):
                begin
                    word.kind = dop_pkg::K_CHECK;
                    word.expect_byte = dop_pkg::COOKIE1;
                    word.err = dop_pkg::ST_COOKIE;
                end
                dop_pkg::OFF_W'(dop_pkg::OFF_CK2):
                begin
                    word.kind = dop_pkg::K_CHECK;
                    word.expect_byte = dop_pkg::COOKIE2;
                    word.err = dop_pkg::ST_COOKIE;
                end
                dop_pkg::OFF_W'(dop_pkg::OFF_CK3):
                begin
                    word.kind = dop_pkg::K_CHECK;
                    word.expect_byte = dop_pkg::COOKIE3;
                    word.err = dop_pkg::ST_COOKIE;
                    word.hdr_end = 1'b1;
                end
                default:
                begin
                    word.kind = dop_pkg::K_IGNORE;
                end
            endcase
        end
    end

endmodule

>>> src/dop_queue.sv
`timescale 1ns / 1ps

module dop_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dop_pkg::cls_word_t push_word,
    output logic               not_full,
    input  logic               pop,
    output logic               not_empty,
    output dop_pkg::cls_word_t pop_word
);

    dop_pkg::cls_word_t              mem_reg [dop_pkg::Q_DEPTH];
    logic [dop_pkg::Q_PTR_W-1:0]     wr_ptr_reg;
    logic [dop_pkg::Q_PTR_W-1:0]     wr_ptr_next;
    logic [dop_pkg::Q_PTR_W-1:0]     rd_ptr_reg;
    logic [dop_pkg::Q_PTR_W-1:0]     rd_ptr_next;
    logic [dop_pkg::Q_CNT_W-1:0]     cnt_reg;
    logic [dop_pkg::Q_CNT_W-1:0]     cnt_next;

    assign not_full  = cnt_reg != dop_pkg::Q_CNT_W'(dop_pkg::Q_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign pop_word  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

>>> src/dop_back.sv
`timescale 1ns / 1ps

module dop_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               word_valid,
    input  dop_pkg::cls_word_t word,
    output logic               word_pop,
    output logic               res_valid,
    input  logic               res_ready,
    output dop_pkg::result_t   res
);

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_CODE   = 6'b000010,
        PH_LEN    = 6'b000100,
        PH_VALUE  = 6'b001000,
        PH_DONE   = 6'b010000,
        PH_ERROR  = 6'b100000
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [7:0]       code_reg, code_next;
    logic [7:0]       rem_reg, rem_next;
    logic [7:0]       vidx_reg, vidx_next;
    logic [2:0]       err_reg, err_next;
    logic [31:0]      ip_reg, ip_next;
    logic [31:0]      mask_reg, mask_next;
    logic [31:0]      rtr_reg, rtr_next;
    logic [31:0]      dns_reg, dns_next;
    logic             out_valid_reg, out_valid_next;
    dop_pkg::result_t out_reg, out_next;

    logic       take;
    logic       cap_ok;
    logic [7:0] vidx_inc;
    logic [2:0] st;

    assign word_pop  = word_valid && (!word.last || !out_valid_reg || res_ready);
    assign take      = word_pop;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign vidx_inc  = vidx_reg + 1'b1;
    assign cap_ok    = rem_reg >= dop_pkg::CAP_BYTES && vidx_reg < dop_pkg::CAP_BYTES;

    always_comb
    begin
        phase_next = phase_reg;
        code_next  = code_reg;
        rem_next   = rem_reg;
        vidx_next  = vidx_reg;
        err_next   = err_reg;
        ip_next    = ip_reg;
        mask_next  = mask_reg;
        rtr_next   = rtr_reg;
        dns_next   = dns_reg;
        if (take)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (word.kind == dop_pkg::K_CHECK)
                    begin
                        if (word.data != word.expect_byte)
                        begin
                            err_next   = word.err;
                            phase_next = PH_ERROR;
                        end
                        else if (word.hdr_end)
                        begin
                            phase_next = PH_CODE;
                        end
                    end
                    else if (word.kind == dop_pkg::K_CAPTURE)
                    begin
                        ip_next = {ip_reg[23:0], word.data};
                    end
                end
                PH_CODE:
                begin
                    if (word.kind == dop_pkg::K_OPTION)
                    begin
                        if (word.data == dop_pkg::OPT_END)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (word.data != dop_pkg::OPT_PAD)
                        begin
                            code_next  = word.data;
                            phase_next = PH_LEN;
                        end
                    end
                end
                PH_LEN:
                begin
                    if (word.kind == dop_pkg::K_OPTION)
                    begin
                        rem_next   = word.data;
                        vidx_next  = '0;
                        phase_next = (word.data == 8'd0) ? PH_CODE : PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    if (word.kind == dop_pkg::K_OPTION)
                    begin
                        if (cap_ok)
                        begin
                            if (code_reg == dop_pkg::OPT_MASK)
                            begin
                                mask_next = {mask_reg[23:0], word.data};
                            end
                            else if (code_reg == dop_pkg::OPT_ROUTER)
                            begin
                                rtr_next = {rtr_reg[23:0], word.data};
                            end
                            else if (code_reg == dop_pkg::OPT_DNS)
                            begin
                                dns_next = {dns_reg[23:0], word.data};
                            end
                        end
                        vidx_next = vidx_inc;
                        if (vidx_inc >= rem_reg)
                        begin
                            phase_next = PH_CODE;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        case (phase_next)
            PH_ERROR: st = err_next;
            PH_DONE:  st = dop_pkg::ST_OK;
            default:  st = dop_pkg::ST_TRUNCATED;
        endcase

        out_next.status      = st;
        out_next.bound       = st == dop_pkg::ST_OK;
        out_next.offered_ip  = (st == dop_pkg::ST_OK) ? ip_next : 32'd0;
        out_next.subnet_mask = (st == dop_pkg::ST_OK) ? mask_next : 32'd0;
        out_next.router_ip   = (st == dop_pkg::ST_OK) ? rtr_next : 32'd0;
        out_next.dns_ip      = (st == dop_pkg::ST_OK) ? dns_next : 32'd0;

        out_valid_next = out_valid_reg && !res_ready;
        if (take && word.last)
        begin
            out_valid_next = 1'b1;
            phase_next = PH_HEADER;
            code_next  = '0;
            rem_next   = '0;
            vidx_next  = '0;
            err_next   = '0;
            ip_next    = '0;
            mask_next  = '0;
            rtr_next   = '0;
            dns_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            code_reg      <= '0;
            rem_reg       <= '0;
            vidx_reg      <= '0;
            err_reg       <= '0;
            ip_reg        <= '0;
            mask_reg      <= '0;
            rtr_reg       <= '0;
            dns_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            code_reg      <= code_next;
            rem_reg       <= rem_next;
            vidx_reg      <= vidx_next;
            err_reg       <= err_next;
            ip_reg        <= ip_next;
            mask_reg      <= mask_next;
            rtr_reg       <= rtr_next;
            dns_reg       <= dns_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && word.last)
        begin
            out_reg <= out_next;
        end
    end

endmodule

>>> src/dhcp_offer_parser_unit.sv
// m_tvalid rises when the back option walker pops the last frame byte and registers the result.
// Throughput: one frame byte per cycle; the front classifier, a four-entry queue and the
// back option walker each move one byte a cycle, the queue absorbing output stalls until full.
// Reset (rst_n, async, active low): offset, parse state, captures, queue and output
// valid clear; transaction_id clears to zero.
`timescale 1ns / 1ps

module dhcp_offer_parser_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // frame_last
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata    // status, bound, offered_ip, subnet_mask, router_ip,
                                    // dns_ip, zero fill
);

    dop_pkg::cls_word_t front_word;
    dop_pkg::cls_word_t q_word;
    dop_pkg::result_t   res;
    logic               q_not_full;
    logic               q_not_empty;
    logic               q_pop;
    logic               push;

    assign s_tready = q_not_full;
    assign push     = s_tvalid && q_not_full;

    dop_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (q_not_full),
        .in_data     (s_tdata),
        .in_last     (s_tlast),
        .word        (front_word)
    );

    dop_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (front_word),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_word  (q_word)
    );

    dop_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (q_not_empty),
        .word       (q_word),
        .word_pop   (q_pop),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {4'd0, res};

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import dop_pkg::*;

    typedef enum logic [2:0] {
        W_HEADER,
        W_CODE,
        W_LEN,
        W_VALUE,
        W_DONE,
        W_FAILED
    } walk_e;

    typedef enum int {
        RC_END_ONLY,
        RC_FULL,
        RC_PAD_SHORT,
        RC_REPEAT,
        RC_NO_END,
        RC_LONG,
        RC_BEYOND_LIMIT,
        RC_OVERLONG,
        RC_RANDOM
    } opt_recipe_e;

    typedef enum int {
        FILL_RAND,
        FILL_ZERO,
        FILL_ONES
    } fill_e;

    typedef struct {
        logic [31:0] xid;
        fill_e       fill_mode;
        opt_recipe_e recipe;
        int          fault_off;
        logic [7:0]  fault_val;
        int          cut_len;
        bit          typed;
        logic [2:0]  typed_status;
    } dir_row_t;

    localparam int NO_FAULT = -1;
    localparam int KEEP_ALL = 0;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [31:0]  cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;   // [7:0] data_byte
    logic         s_tlast;   // frame_last
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;   // status, bound, offered_ip, subnet_mask, router_ip, dns_ip

    dhcp_offer_parser_unit uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // predictor state
    logic [31:0] xid_reg = '0;
    int          walk_off = 0;
    walk_e       walk_state = W_HEADER;
    logic [7:0]  opt_code = '0;
    logic [7:0]  opt_left = '0;
    logic [7:0]  opt_idx = '0;
    logic [2:0]  walk_err = ST_OK;
    logic [31:0] walk_cap [4] = '{default: '0};

    result_t     pending_offers[$];
    bit          use_typed = 1'b0;
    result_t     typed_res;
    int          fail_count = 0;

    int          gap_pct = 0;
    int          stall_pct = 0;
    int          hold_req = 0;
    int          hold_left = 0;

    logic [7:0]  frame_bytes[$];
    fill_e       fill_mode = FILL_RAND;
    int          checked_offs[$] = '{OFF_IP_VER, OFF_PROTO, OFF_SPORT_HI, OFF_SPORT_LO,
                                     OFF_DPORT_HI, OFF_DPORT_LO, OFF_OP, OFF_HTYPE, OFF_HLEN,
                                     OFF_XID0, OFF_XID1, OFF_XID2, OFF_XID3,
                                     OFF_CK0, OFF_CK1, OFF_CK2, OFF_CK3};

    result_t     got;
    result_t     want;

    function automatic void predict_offer_byte(input logic [7:0] b, input logic is_last);
        logic [2:0] fail_st;
        logic [7:0] ck;
        int         slot;
        result_t    res;
        fail_st = ST_OK;
        if (walk_off < MAX_FRAME_BYTES)
        begin
            if (walk_state == W_HEADER)
            begin
                case (walk_off)
                    OFF_IP_VER: if (b != IP_VER_IHL) fail_st = ST_IP_HDR;
                    OFF_PROTO: if (b != PROTO_UDP) fail_st = ST_NOT_UDP;
                    OFF_SPORT_HI, OFF_DPORT_HI: if (b != 8'd0) fail_st = ST_PORTS;
                    OFF_SPORT_LO: if (b != PORT_SERVER) fail_st = ST_PORTS;
                    OFF_DPORT_LO: if (b != PORT_CLIENT) fail_st = ST_PORTS;
                    OFF_OP: if (b != OP_REPLY) fail_st = ST_BOOTP;
                    OFF_HTYPE: if (b != HTYPE_ETH) fail_st = ST_BOOTP;
                    OFF_HLEN: if (b != HLEN_ETH) fail_st = ST_BOOTP;
                    OFF_XID0, OFF_XID1, OFF_XID2, OFF_XID3:
                        if (8'(xid_reg >> ((OFF_XID3 - walk_off) * 8)) != b) fail_st = ST_XID;
                    default:
                    begin
                        if (walk_off >= OFF_YI0 && walk_off <= OFF_YI3)
                            walk_cap[0] = {walk_cap[0][23:0], b};
                        else if (walk_off >= OFF_CK0 && walk_off <= OFF_CK3)
                        begin
                            ck = (walk_off == OFF_CK0) ? COOKIE0 :
                                 (walk_off == OFF_CK1) ? COOKIE1 :
                                 (walk_off == OFF_CK2) ? COOKIE2 : COOKIE3;
                            if (b != ck)
                                fail_st = ST_COOKIE;
                            else if (walk_off == OFF_CK3)
                                walk_state = W_CODE;
                        end
                    end
                endcase
                if (fail_st != ST_OK)
                begin
                    walk_err = fail_st;
                    walk_state = W_FAILED;
                end
            end
            else if ((walk_state == W_CODE || walk_state == W_LEN || walk_state == W_VALUE)
                     && walk_off >= OFF_OPT)
            begin
                case (walk_state)
                    W_CODE:
                    begin
                        if (b == OPT_END)
                            walk_state = W_DONE;
                        else if (b != OPT_PAD)
                        begin
                            opt_code = b;
                            walk_state = W_LEN;
                        end
                    end
                    W_LEN:
                    begin
                        opt_left = b;
                        opt_idx = 8'd0;
                        walk_state = (b == 8'd0) ? W_CODE : W_VALUE;
                    end
                    default:
                    begin
                        slot = (opt_code == OPT_MASK) ? 1 :
                               (opt_code == OPT_ROUTER) ? 2 :
                               (opt_code == OPT_DNS) ? 3 : 0;
                        // short options capture nothing, long ones only the first four bytes
                        if (slot != 0 && opt_left >= CAP_BYTES && opt_idx < CAP_BYTES)
                            walk_cap[slot] = {walk_cap[slot][23:0], b};
                        opt_idx = opt_idx + 8'd1;
                        if (opt_idx >= opt_left)
                            walk_state = W_CODE;
                    end
                endcase
            end
            walk_off++;
        end
        if (is_last)
        begin
            res = '0;
            if (walk_state == W_FAILED)
                res.status = walk_err;
            else if (walk_state == W_DONE)
                res.status = ST_OK;
            else
                res.status = ST_TRUNCATED;
            if (res.status == ST_OK)
            begin
                res.bound = 1'b1;
                res.offered_ip = walk_cap[0];
                res.subnet_mask = walk_cap[1];
                res.router_ip = walk_cap[2];
                res.dns_ip = walk_cap[3];
            end
            pending_offers.push_back(use_typed ? typed_res : res);
            walk_off = 0;
            walk_state = W_HEADER;
            opt_code = '0;
            opt_left = '0;
            opt_idx = '0;
            walk_err = ST_OK;
            walk_cap = '{default: '0};
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[131:0];
            if (pending_offers.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, m_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_offers.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("bound", 32'(want.bound), 32'(got.bound));
                check_field("offered_ip", want.offered_ip, got.offered_ip);
                check_field("subnet_mask", want.subnet_mask, got.subnet_mask);
                check_field("router_ip", want.router_ip, got.router_ip);
                check_field("dns_ip", want.dns_ip, got.dns_ip);
            end
        end
    end

    // output side: random stalls plus long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req <= 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [7:0] fill_byte();
        case (fill_mode)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom);
        endcase
    endfunction

    function automatic void put_opt(input logic [7:0] code, input int len);
        frame_bytes.push_back(code);
        frame_bytes.push_back(8'(len));
        repeat (len) frame_bytes.push_back(fill_byte());
    endfunction

    function automatic void build_frame(input opt_recipe_e recipe);
        int         n;
        int         k;
        logic [7:0] code;
        frame_bytes.delete();
        for (int i = 0; i < OFF_OPT; i++)
            frame_bytes.push_back(fill_byte());
        frame_bytes[OFF_IP_VER]   = IP_VER_IHL;
        frame_bytes[OFF_PROTO]    = PROTO_UDP;
        frame_bytes[OFF_SPORT_HI] = 8'd0;
        frame_bytes[OFF_SPORT_LO] = PORT_SERVER;
        frame_bytes[OFF_DPORT_HI] = 8'd0;
        frame_bytes[OFF_DPORT_LO] = PORT_CLIENT;
        frame_bytes[OFF_OP]       = OP_REPLY;
        frame_bytes[OFF_HTYPE]    = HTYPE_ETH;
        frame_bytes[OFF_HLEN]     = HLEN_ETH;
        frame_bytes[OFF_XID0]     = xid_reg[31:24];
        frame_bytes[OFF_XID1]     = xid_reg[23:16];
        frame_bytes[OFF_XID2]     = xid_reg[15:8];
        frame_bytes[OFF_XID3]     = xid_reg[7:0];
        frame_bytes[OFF_CK0]      = COOKIE0;
        frame_bytes[OFF_CK1]      = COOKIE1;
        frame_bytes[OFF_CK2]      = COOKIE2;
        frame_bytes[OFF_CK3]      = COOKIE3;
        case (recipe)
            RC_END_ONLY:
                frame_bytes.push_back(OPT_END);
            RC_FULL:
            begin
                put_opt(OPT_MASK, 4);
                put_opt(OPT_ROUTER, 4);
                put_opt(OPT_DNS, 8);
                frame_bytes.push_back(OPT_END);
            end
            RC_PAD_SHORT:
            begin
                frame_bytes.push_back(OPT_PAD);
                frame_bytes.push_back(OPT_PAD);
                put_opt(OPT_MASK, 3);
                put_opt(OPT_ROUTER, 0);
                put_opt(OPT_DNS, 4);
                frame_bytes.push_back(OPT_PAD);
                put_opt(8'd50, 5);
                put_opt(OPT_ROUTER, 2);
                frame_bytes.push_back(OPT_END);
            end
            RC_REPEAT:
            begin
                put_opt(OPT_MASK, 4);
                put_opt(OPT_MASK, 4);
                put_opt(OPT_DNS, 4);
                put_opt(OPT_DNS, 12);
                put_opt(OPT_ROUTER, 4);
                put_opt(8'd53, 1);
                frame_bytes.push_back(OPT_END);
                // junk after end must be ignored
                put_opt(OPT_MASK, 4);
                frame_bytes.push_back(OPT_END);
                frame_bytes.push_back(OPT_PAD);
                repeat (5) frame_bytes.push_back(8'($urandom));
            end
            RC_NO_END:
            begin
                put_opt(OPT_MASK, 4);
                put_opt(OPT_ROUTER, 4);
                put_opt(OPT_DNS, 4);
                put_opt(8'd12, 6);
            end
            RC_LONG:
            begin
                put_opt(OPT_MASK, 255);
                put_opt(OPT_DNS, 5);
                put_opt(8'd200, 255);
                put_opt(OPT_ROUTER, 7);
                frame_bytes.push_back(OPT_END);
            end
            RC_BEYOND_LIMIT:
            begin
                while (frame_bytes.size() <= MAX_FRAME_BYTES)
                    put_opt(8'd43, 255);
                frame_bytes.push_back(OPT_END);
            end
            RC_OVERLONG:
            begin
                while (frame_bytes.size() < MAX_FRAME_BYTES - 20)
                    put_opt(8'($urandom_range(1, 254)), $urandom_range(0, 255));
                if ($urandom_range(1))
                    frame_bytes.push_back(OPT_END);
                n = MAX_FRAME_BYTES + $urandom_range(1, 40);
                while (frame_bytes.size() < n)
                    frame_bytes.push_back(8'($urandom));
            end
            default:
            begin
                n = $urandom_range(0, 8);
                repeat (n)
                begin
                    k = $urandom_range(99);
                    if (k < 12)
                        frame_bytes.push_back(OPT_PAD);
                    else
                    begin
                        code = (k < 32) ? OPT_MASK :
                               (k < 52) ? OPT_ROUTER :
                               (k < 72) ? OPT_DNS : 8'($urandom_range(1, 254));
                        put_opt(code, ($urandom_range(9) < 8) ? $urandom_range(0, 8)
                                                               : $urandom_range(0, 255));
                    end
                end
                if ($urandom_range(9) != 0)
                begin
                    frame_bytes.push_back(OPT_END);
                    repeat ($urandom_range(0, 6)) frame_bytes.push_back(8'($urandom));
                end
            end
        endcase
    endfunction

    function automatic void make_random_frame();
        int r;
        int off;
        int cut;
        r = $urandom_range(99);
        fill_mode = ($urandom_range(19) == 0) ? FILL_ZERO :
                    ($urandom_range(19) == 0) ? FILL_ONES : FILL_RAND;
        if (r < 97)
            build_frame(RC_RANDOM);
        if (r >= 55 && r < 72)
        begin
            off = checked_offs[$urandom_range(checked_offs.size() - 1)];
            frame_bytes[off] = frame_bytes[off] ^ 8'($urandom_range(1, 255));
        end
        else if (r >= 72 && r < 87)
        begin
            cut = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > cut)
                void'(frame_bytes.pop_back());
        end
        else if (r >= 87 && r < 97)
        begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 64)) frame_bytes.push_back(8'($urandom));
        end
        else if (r >= 97)
            build_frame(RC_OVERLONG);
    endfunction

    // entered and left at a falling edge
    task automatic push_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_offer_byte(b, is_last);
        @(negedge clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_offers.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_xid(input logic [31:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        xid_reg = v;
        @(negedge clk);
    endtask

    function automatic dir_row_t mk_row(input logic [31:0] xid, input fill_e fm,
                                        input opt_recipe_e rc, input int f_off,
                                        input logic [7:0] f_val, input int cut,
                                        input bit typed, input logic [2:0] st);
        dir_row_t r;
        r.xid = xid;
        r.fill_mode = fm;
        r.recipe = rc;
        r.fault_off = f_off;
        r.fault_val = f_val;
        r.cut_len = cut;
        r.typed = typed;
        r.typed_status = st;
        return r;
    endfunction

    initial
    begin
        dir_row_t dir_rows[$];
        int       gaps[4];
        int       stalls[4];
        int       nbytes;
        int       nframes;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        gaps = '{0, 53, 0, 19};
        stalls = '{0, 0, 53, 19};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        dir_rows = '{
            mk_row(32'h0, FILL_RAND, RC_FULL, NO_FAULT, 8'h00, KEEP_ALL, 1'b0, ST_OK),
            mk_row(32'h0, FILL_ZERO, RC_END_ONLY, NO_FAULT, 8'h00, KEEP_ALL, 1'b0, ST_OK),
            mk_row(32'h0, FILL_ONES, RC_FULL, NO_FAULT, 8'h00, KEEP_ALL, 1'b0, ST_OK),
            mk_row(32'h0, FILL_RAND, RC_FULL, NO_FAULT, 8'h00, 1, 1'b1, ST_TRUNCATED),
            mk_row(32'h0, FILL_RAND, RC_FULL, OFF_IP_VER, 8'h46, KEEP_ALL, 1'b1, ST_IP_HDR),
            mk_row(32'h0, FILL_RAND, RC_FULL, OFF_PROTO, 8'd6, KEEP_ALL, 1'b1, ST_NOT_UDP),
            mk_row(32'h0, FILL_RAND, RC_FULL, OFF_SPORT_HI, 8'hFF, KEEP_ALL, 1'b1, ST_PORTS),
            mk_row(32'h0, FILL_RAND, RC_FULL, OFF_SPORT_LO, 8'd68, KEEP_ALL, 1'b1, ST_PORTS),
            mk_row(32'h0, FILL_RAND, RC_FULL, OFF_DPORT_HI, 8'd1, KEEP_ALL, 1'b1, ST_PORTS),
            mk_row(32'h0, FILL_RAND, RC_FULL, OFF_DPORT_LO, 8'd67, KEEP_ALL, 1'b1, ST_PORTS),
            mk_row(32'h0, FILL_RAND, RC_FULL, OFF_OP, 8'd1, KEEP_ALL, 1'b1, ST_BOOTP),
            mk_row(32'h0, FILL_RAND, RC_FULL, OFF_HTYPE, 8'd0, KEEP_ALL, 1'b1, ST_BOOTP),
            mk_row(32'h0, FILL_RAND, RC_FULL, OFF_HLEN, 8'hFF, KEEP_ALL, 1'b1, ST_BOOTP),
            mk_row(32'hFFFF_FFFF, FILL_RAND, RC_FULL, NO_FAULT, 8'h00, KEEP_ALL, 1'b0, ST_OK),
            mk_row(32'hFFFF_FFFF, FILL_RAND, RC_FULL, OFF_XID0, 8'hFE, KEEP_ALL, 1'b1, ST_XID),
            mk_row(32'hFFFF_FFFF, FILL_RAND, RC_FULL, OFF_XID3, 8'h7F, KEEP_ALL, 1'b1, ST_XID),
            mk_row(32'h0, FILL_ONES, RC_FULL, OFF_XID1, 8'h01, KEEP_ALL, 1'b1, ST_XID),
            mk_row(32'h0, FILL_RAND, RC_FULL, OFF_CK0, 8'h62, KEEP_ALL, 1'b1, ST_COOKIE),
            mk_row(32'h0, FILL_RAND, RC_FULL, OFF_CK3, 8'h00, KEEP_ALL, 1'b1, ST_COOKIE),
            mk_row(32'h0, FILL_RAND, RC_PAD_SHORT, NO_FAULT, 8'h00, KEEP_ALL, 1'b0, ST_OK),
            mk_row(32'h0, FILL_RAND, RC_REPEAT, NO_FAULT, 8'h00, KEEP_ALL, 1'b0, ST_OK),
            mk_row(32'h0, FILL_RAND, RC_NO_END, NO_FAULT, 8'h00, KEEP_ALL, 1'b1, ST_TRUNCATED),
            mk_row(32'h0, FILL_RAND, RC_FULL, NO_FAULT, 8'h00, OFF_OPT, 1'b1, ST_TRUNCATED),
            mk_row(32'h0, FILL_RAND, RC_LONG, NO_FAULT, 8'h00, KEEP_ALL, 1'b0, ST_OK),
            mk_row(32'h0, FILL_RAND, RC_BEYOND_LIMIT, NO_FAULT, 8'h00, KEEP_ALL, 1'b1,
                   ST_TRUNCATED)
        };

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].xid != xid_reg)
            begin
                wait_drained();
                write_xid(dir_rows[i].xid);
            end
            fill_mode = dir_rows[i].fill_mode;
            build_frame(dir_rows[i].recipe);
            if (dir_rows[i].fault_off != NO_FAULT)
                frame_bytes[dir_rows[i].fault_off] = dir_rows[i].fault_val;
            if (dir_rows[i].cut_len != KEEP_ALL)
                while (frame_bytes.size() > dir_rows[i].cut_len)
                    void'(frame_bytes.pop_back());
            use_typed = dir_rows[i].typed;
            typed_res = '0;
            typed_res.status = dir_rows[i].typed_status;
            send_frame();
        end
        use_typed = 1'b0;

        // output held off while tiny frames keep coming, so the input backs up
        wait_drained();
        hold_req <= 400;
        repeat (40)
        begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
            send_frame();
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_drained();
            gap_pct = gaps[ph];
            stall_pct = stalls[ph];
            write_xid($urandom);
            nbytes = 0;
            nframes = 0;
            while (nbytes < 365 || nframes < 16)
            begin
                make_random_frame();
                nbytes += frame_bytes.size();
                nframes++;
                send_frame();
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("dhcp_offer_parser_unit verification clean");
        else
            $display("dhcp_offer_parser_unit verification failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("dhcp_offer_parser_unit verification failed");
        $finish;
    end

endmodule
